// ===== hdl/blwd_pkg.sv =====
// Shared constants for the bounded list with delete-before.
// Operation and status codes and field widths; no dependencies.
package blwd_pkg;

   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   // Operation codes carried on req_tuser
   localparam logic [OP_W-1:0] OP_INSERT_FRONT  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT_END    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE_LAST   = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE_BEFORE = 2'd3;

   // Status codes carried on rsp_tuser
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_PRED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

// ===== hdl/blwd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module blwd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bounded_list_with_delete_before_core.sv =====
// Channel  | Direction | tdata                  | tuser
// ---------+-----------+------------------------+----------------------
// req_     | in        | [31:0] value           | [1:0] operation
// rsp_     | out       | [31:0] result_value    | [2:0] status
//
// One item at a time. An insert writes the list memory and then hands its result to the
// output register; delete last reads the last entry first. Delete before scans from the
// front for the key, then closes the gap by moving each later entry one slot forward.
// Scan and gap closing both use the single read port of the list memory, one entry a cycle.
// Synchronous active-high reset empties the list at once; no clearing pass.
// A stalled result sits in the output register while the next transfer is taken.
//
// Top level of the bounded list; depends on blwd_pkg and blwd_ram.
module bounded_list_with_delete_before_core
   import blwd_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,   // [31:0] value
   input  logic [OP_W-1:0]     req_tuser,   // [1:0] operation
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [VALUE_W-1:0]  rsp_tdata,   // [31:0] result_value
   output logic [STATUS_W-1:0] rsp_tuser    // [2:0] status
);

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LAST  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   // Ring slot of a list position
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] first,
                                                input logic [CNT_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(first) + SUM_W'(pos);
      if (sum >= SUM_W'(LIST_DEPTH)) begin
         sum = sum - SUM_W'(LIST_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    first_ff, first_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0]    cmp_pos_ff, cmp_pos_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [VALUE_W-1:0]  key_ff, key_in;
   logic [VALUE_W-1:0]  prev_ff, prev_in;
   logic [VALUE_W-1:0]  res_val_ff, res_val_in;
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [VALUE_W-1:0]  rsp_val_ff, rsp_val_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [VALUE_W-1:0]  rd_data;

   logic                req_fire;
   logic                list_full;
   logic                list_empty;
   logic [CNT_W-1:0]    cnt_last;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign list_full  = (count_ff == CNT_W'(LIST_DEPTH));
   assign list_empty = (count_ff == '0);
   assign cnt_last   = count_ff - CNT_W'(1);

   blwd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: operation decode, key scan and gap closing
   always_comb begin
      state_in   = state_ff;
      first_in   = first_ff;
      count_in   = count_ff;
      rd_pos_in  = rd_pos_ff;
      cmp_pos_in = cmp_pos_ff;
      cmp_vld_in = cmp_vld_ff;
      key_in     = key_ff;
      prev_in    = prev_ff;
      res_val_in = res_val_ff;
      res_st_in  = res_st_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_val_in = rsp_val_ff;
      rsp_st_in  = rsp_st_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;

      // drop the result once the transfer completes
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  OP_INSERT_FRONT, OP_INSERT_END: begin
                     if (list_full) begin
                        res_val_in = '0;
                        res_st_in  = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = req_tdata;
                        if (req_tuser == OP_INSERT_FRONT) begin
                           first_in = (first_ff == '0) ? IDX_W'(LIST_DEPTH - 1)
                                                       : first_ff - IDX_W'(1);
                           wr_addr  = first_in;
                        end else begin
                           wr_addr = slot_of(first_ff, count_ff);
                        end
                        count_in   = count_ff + CNT_W'(1);
                        res_val_in = req_tdata;
                        res_st_in  = ST_OK;
                     end
                     state_in = S_RESP;
                  end
                  OP_DELETE_LAST: begin
                     if (list_empty) begin
                        res_val_in = '0;
                        res_st_in  = ST_EMPTY;
                        state_in   = S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(first_ff, cnt_last);
                        state_in = S_LAST;
                     end
                  end
                  OP_DELETE_BEFORE: begin
                     if (list_empty) begin
                        res_val_in = '0;
                        res_st_in  = ST_EMPTY;
                        state_in   = S_RESP;
                     end else begin
                        key_in     = req_tdata;
                        rd_pos_in  = '0;
                        cmp_vld_in = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_LAST: begin
            res_val_in = rd_data;
            res_st_in  = ST_OK;
            count_in   = cnt_last;
            state_in   = S_RESP;
         end

         S_SCAN: begin
            // stream reads from the front, one position a cycle
            cmp_vld_in = 1'b0;
            if (rd_pos_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = slot_of(first_ff, rd_pos_ff);
               rd_pos_in  = rd_pos_ff + CNT_W'(1);
               cmp_pos_in = rd_pos_ff;
               cmp_vld_in = 1'b1;
            end
            // compare the entry that came back
            if (cmp_vld_ff) begin
               if (rd_data == key_ff) begin
                  if (cmp_pos_ff == '0) begin
                     res_val_in = '0;
                     res_st_in  = ST_NO_PRED;
                     state_in   = S_RESP;
                  end else if (cmp_pos_ff == CNT_W'(1)) begin
                     res_val_in = prev_ff;
                     res_st_in  = ST_OK;
                     first_in   = slot_of(first_ff, CNT_W'(1));
                     count_in   = cnt_last;
                     state_in   = S_RESP;
                  end else begin
                     res_val_in = prev_ff;
                     res_st_in  = ST_OK;
                     rd_pos_in  = cmp_pos_ff;
                     cmp_vld_in = 1'b0;
                     state_in   = S_SHIFT;
                  end
               end else if (cmp_pos_ff == cnt_last) begin
                  res_val_in = '0;
                  res_st_in  = ST_NOT_FOUND;
                  state_in   = S_RESP;
               end else begin
                  prev_in = rd_data;
               end
            end
         end

         S_SHIFT: begin
            // read position i, write it back one slot toward the front
            cmp_vld_in = 1'b0;
            if (rd_pos_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = slot_of(first_ff, rd_pos_ff);
               rd_pos_in  = rd_pos_ff + CNT_W'(1);
               cmp_pos_in = rd_pos_ff;
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = slot_of(first_ff, cmp_pos_ff - CNT_W'(1));
               wr_data = rd_data;
               if (cmp_pos_ff == cnt_last) begin
                  count_in = cnt_last;
                  state_in = S_RESP;
               end
            end
         end

         S_RESP: begin
            // hand the result to the output register when it is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               rsp_val_in = res_val_ff;
               rsp_st_in  = res_st_ff;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         first_ff   <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         first_ff   <= first_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload and position registers
   always_ff @(posedge clock) begin
      rd_pos_ff  <= rd_pos_in;
      cmp_pos_ff <= cmp_pos_in;
      key_ff     <= key_in;
      prev_ff    <= prev_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_st_ff;

endmodule

// ===== hdl/blwd_checker.sv =====
// Port-level checks for the bounded list, bound to the top level.
// Depends on blwd_pkg and bounded_list_with_delete_before_core.
module blwd_checker
   import blwd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [VALUE_W-1:0]  req_tdata,
   input logic [OP_W-1:0]     req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [VALUE_W-1:0]  rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   // Status stays within the defined codes
   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_EMPTY ||
                      rsp_tuser == ST_NOT_FOUND || rsp_tuser == ST_NO_PRED ||
                      rsp_tuser == ST_FULL))
      else $error("undefined status code");

   // Any refused operation returns a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("non-zero value with error status");

   // Only one item in work: no back-to-back transfers on the request side
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in work");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // A request transfer carries known fields
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !$isunknown({req_tdata, req_tuser}))
      else $error("unknown request fields at transfer");

endmodule

bind bounded_list_with_delete_before_core blwd_checker u_blwd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_bounded_list_with_delete_before_core.sv =====
// Testbench for the bounded list with delete-before: directed corner items, then random traffic.
// A scoreboard mirrors the list contents and checks every response transfer in order.
// Depends on blwd_pkg and bounded_list_with_delete_before_core.
module tb_bounded_list_with_delete_before_core;
   timeunit 1ns;
   timeprecision 1ps;

   import blwd_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 525;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } list_result_type;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_type;

   // Mirror of the list and the queue of responses still owed by the block
   class list_scoreboard;
      logic [VALUE_W-1:0] mirror_list[$];
      list_result_type    expected_results[$];
      int                 depth;
      int                 errors;

      function new(int list_depth);
         depth  = list_depth;
         errors = 0;
      endfunction

      // Apply one accepted request to the mirror and queue its response
      function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
         list_result_type r;
         int              pos;
         r.value  = '0;
         r.status = ST_OK;
         pos      = -1;
         case (op)
            OP_INSERT_FRONT, OP_INSERT_END: begin
               if (mirror_list.size() >= depth) begin
                  r.status = ST_FULL;
               end else begin
                  if (op == OP_INSERT_FRONT) mirror_list.push_front(val);
                  else mirror_list.push_back(val);
                  r.value = val;
               end
            end
            default: begin
               if (mirror_list.size() == 0) begin
                  r.status = ST_EMPTY;
               end else if (op == OP_DELETE_LAST) begin
                  r.value = mirror_list.pop_back();
               end else begin
                  // only the match nearest the front counts
                  for (int i = 0; i < mirror_list.size() && pos < 0; i++)
                     if (mirror_list[i] == val) pos = i;
                  if (pos < 0) begin
                     r.status = ST_NOT_FOUND;
                  end else if (pos == 0) begin
                     r.status = ST_NO_PRED;
                  end else begin
                     r.value = mirror_list[pos-1];
                     mirror_list.delete(pos-1);
                  end
               end
            end
         endcase
         expected_results.push_back(r);
      endfunction

      // Compare one response transfer with the oldest expectation
      function void check_response(logic [VALUE_W-1:0] val, logic [STATUS_W-1:0] status);
         list_result_type r;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, value %h status %0d", $time, val, status);
            errors++;
         end else begin
            r = expected_results.pop_front();
            if (val !== r.value) begin
               $display("%0t: result value expected %h actual %h", $time, r.value, val);
               errors++;
            end
            if (status !== r.status) begin
               $display("%0t: status expected %0d actual %0d", $time, r.status, status);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata;   // [31:0] value
   logic [OP_W-1:0]     req_tuser;   // [1:0] operation
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [VALUE_W-1:0]  rsp_tdata;   // [31:0] result_value
   logic [STATUS_W-1:0] rsp_tuser;   // [2:0] status

   list_scoreboard sb;

   bounded_list_with_delete_before_core #(
      .LIST_DEPTH(LIST_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Present one request and hold it until the transfer; valid stays high afterwards
   task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, val);
   endtask

   // Drop valid for a number of cycles
   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tuser  <= OP_W'($urandom());
      req_tdata  <= VALUE_W'($urandom());
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Draw a value: often ones already held, so keys hit and duplicates build up
   function automatic logic [VALUE_W-1:0] pick_value();
      int                 sel;
      logic [VALUE_W-1:0] val;
      sel = $urandom_range(0, 99);
      if (sel < 45 && sb.mirror_list.size() != 0)
         val = sb.mirror_list[$urandom_range(0, sb.mirror_list.size() - 1)];
      else if (sel < 70)
         val = int'($urandom_range(0, 7)) - 4;
      else if (sel < 80)
         case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'h0000_0000;
            default: val = 32'hffff_ffff;
         endcase
      else
         val = $urandom();
      return val;
   endfunction

   // Draw an operation, leaning towards filling or draining the list
   function automatic logic [OP_W-1:0] pick_op(bit filling);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return OP_W'($urandom_range(0, 3));
      if (filling) begin
         if (sel < 40) return OP_INSERT_FRONT;
         if (sel < 70) return OP_INSERT_END;
         if (sel < 82) return OP_DELETE_LAST;
         return OP_DELETE_BEFORE;
      end
      if (sel < 20) return OP_INSERT_FRONT;
      if (sel < 30) return OP_INSERT_END;
      if (sel < 52) return OP_DELETE_LAST;
      return OP_DELETE_BEFORE;
   endfunction

   // Receiver: stall on its own pattern, switching between open, light and heavy
   initial begin : rx_pattern
      rx_mode_type mode;
      int          stall_left;
      int          mode_left;
      mode       = RX_OPEN;
      stall_left = 0;
      mode_left  = 80;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            case (mode)
               RX_LIGHT: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 4);
               RX_HEAVY: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 12);
               default: ;
            endcase
         end
      end
   end

   // Check every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
   end

   // Main sequence: reset, directed items, random bursts, drain
   initial begin : main_seq
      int  burst_left;
      int  phase_left;
      bit  filling;
      sb         = new(LIST_DEPTH);
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_INSERT_FRONT;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // delete from an empty list, both kinds
      send_request(OP_DELETE_LAST, 32'h0000_0000);
      send_request(OP_DELETE_BEFORE, 32'h0000_0000);
      // extremes, then fill to the brim with two copies of seven
      send_request(OP_INSERT_END, 32'h7fff_ffff);
      send_request(OP_INSERT_FRONT, 32'h8000_0000);
      send_request(OP_INSERT_END, 32'h0000_0000);
      send_request(OP_INSERT_END, 32'hffff_ffff);
      for (int i = 0; i < 12; i++)
         send_request(OP_INSERT_END, (i == 8) ? 32'd7 : 32'(i * 3 + 1));
      // refused inserts into a full list
      send_request(OP_INSERT_FRONT, 32'd1);
      send_request(OP_INSERT_END, 32'd2);
      // key at the front, key absent, predecessor at the front, predecessor further in
      send_request(OP_DELETE_BEFORE, 32'h8000_0000);
      send_request(OP_DELETE_BEFORE, 32'h0012_3456);
      send_request(OP_DELETE_BEFORE, 32'h7fff_ffff);
      send_request(OP_DELETE_BEFORE, 32'hffff_ffff);
      // duplicate key: the first seven decides
      send_request(OP_DELETE_BEFORE, 32'd7);
      send_request(OP_DELETE_LAST, 32'h0000_0000);

      // random traffic in bursts, alternating fill and drain phases
      burst_left = $urandom_range(1, 24);
      phase_left = $urandom_range(20, 60);
      filling    = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150 || n == 350) begin
            // hold off until the block has answered everything
            idle_sender(1);
            while (sb.pending() != 0) @(posedge clock);
         end
         if (phase_left == 0) begin
            filling    = ~filling;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 10));
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
         send_request(pick_op(filling), pick_value());
      end

      // drain: wait for all responses, then keep watching for stray responses
      idle_sender(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * LIST_DEPTH + 10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
